// ----- sv/stt_pkg.sv -----
// ============================================================================
// stt_pkg: shared types and constants for the source text tokenizer
// Holds the token record type, the scanner mode type, the keyword table and
// the keyword lookup used when a word token is closed.
// ============================================================================
package stt_pkg;

    // Default size limit of the token text buffer.
    localparam int MAX_TEXT_SIZE_DEF = 64;

    // Number of token records the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Length of the stored prefix used for keyword matching.
    localparam int PREFIX_LEN = 8;

    // Number of keywords.
    localparam int KW_COUNT = 6;

    // Token class codes as they appear on the output.
    typedef enum logic [2:0] {
        CLS_KEYWORD = 3'd0,
        CLS_IDENT   = 3'd1,
        CLS_NUMBER  = 3'd2,
        CLS_OPER    = 3'd3,
        CLS_SEP     = 3'd4,
        CLS_END     = 3'd5,
        CLS_ERROR   = 3'd6
    } t_cls;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_DIGITS = 3'd2,
        MODE_OPER   = 3'd3,
        MODE_HALT   = 3'd4
    } t_mode;

    // One token record.
    typedef struct packed {
        t_cls        cls;
        logic [2:0]  kw;
        logic [5:0]  len;
        logic        trunc;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [31:0] pos;
        logic        last;
    } t_rec;

    // Records produced by one accepted input beat, compacted into rec0 first.
    typedef struct packed {
        logic [1:0] n;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    // Keyword spellings, first character at index 0, padded with zeros.
    localparam logic [7:0] KW_CHARS [KW_COUNT][PREFIX_LEN] = '{
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd2, 4'd4, 4'd5, 4'd8, 4'd6};

    // Returns {hit, index}. A length of zero never matches.
    function automatic logic [3:0] kw_lookup(input logic [PREFIX_LEN-1:0][7:0] prefix,
                                             input logic [3:0] len);
        logic       eq;
        logic [3:0] res;
        res = 4'd0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            eq = (len == KW_LEN[k]);
            for (int i = 0; i < PREFIX_LEN; i++) begin
                if ((4'(i) < KW_LEN[k]) && (prefix[i] != KW_CHARS[k][i])) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                res = {1'b1, 3'(k)};
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/source_text_tokenizer_unit.sv -----
// ============================================================================
// source_text_tokenizer_unit: streaming lexical analyzer
// Turns a byte stream into token records: words, keywords, numbers,
// operators, separators, end and error records.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   input   | in        | i_in_valid / o_in_ready   | byte, end-of-input mark
//   result  | out       | o_out_valid / i_out_ready | one token record per beat
//
// One input beat is taken per cycle while the record queue has two free slots.
// A record passes the record queue and then the output register on its way out.
// A beat that yields two records puts two into the queue; the output stage sends
// one per cycle while i_out_ready is high, so the queue depth sets how long such
// bursts are absorbed. Reset is synchronous; there is no clearing pass.
// A stalled result channel fills the queue and then drops o_in_ready.
// ============================================================================
module source_text_tokenizer_unit import stt_pkg::*; #(
    parameter int MAX_TEXT_SIZE = MAX_TEXT_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_input_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_token_class,
    output logic [2:0]  o_keyword_index,
    output logic [5:0]  o_token_length,
    output logic        o_truncated,
    output logic [7:0]  o_first_char,
    output logic [7:0]  o_second_char,
    output logic [31:0] o_start_position,
    output logic        o_last_of_run
);

    t_push push;
    logic  space_ok, pop, nonempty;
    t_rec  q_rec, out_rec;

    // Scanner.
    stt_front #(
        .MAX_TEXT_SIZE(MAX_TEXT_SIZE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_input_byte   (i_input_byte),
        .i_end_of_input (i_end_of_input),
        .i_space_ok     (space_ok),
        .o_push         (push)
    );

    // Record queue.
    stt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_rec      (q_rec)
    );

    // Output stage.
    stt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_rec      (q_rec),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_rec      (out_rec)
    );

    // Result fields.
    assign o_token_class    = out_rec.cls;
    assign o_keyword_index  = out_rec.kw;
    assign o_token_length   = out_rec.len;
    assign o_truncated      = out_rec.trunc;
    assign o_first_char     = out_rec.c1;
    assign o_second_char    = out_rec.c2;
    assign o_start_position = out_rec.pos;
    assign o_last_of_run    = out_rec.last;

endmodule

// ----- sv/stt_front.sv -----
// ============================================================================
// stt_front: character scanner
// Accepts one byte or end mark per beat, tracks the token being built and
// produces up to two token records per beat for the record queue.
// ============================================================================
module stt_front import stt_pkg::*; #(
    parameter int MAX_TEXT_SIZE = MAX_TEXT_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_input_byte,
    input  logic       i_end_of_input,
    input  logic       i_space_ok,
    output t_push      o_push
);

    localparam int CW = $clog2(MAX_TEXT_SIZE);

    t_mode                      r_mode, n_mode;
    logic [PREFIX_LEN-1:0][7:0] r_prefix, n_prefix;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic [7:0]                 r_pend, n_pend;
    logic [31:0]                r_start, n_start;
    logic [31:0]                r_pos, n_pos;

    logic       accept, live, is_byte;
    logic       c_letter, c_digit, c_space, c_under, c_op4, c_op1, c_sep;
    logic       cont, op_pair;
    t_mode      start_mode;
    logic [3:0] kw_len, kw_res;
    logic [5:0] word_len;
    logic       flush_v, start_v, va, vb;
    t_rec       flush_rec, start_rec, rec_a, rec_b;
    logic       do_append;
    logic [CW-1:0] app_count;

    assign o_ready = i_space_ok;
    assign accept  = i_valid && o_ready;
    assign live    = accept && (r_mode != MODE_HALT);
    assign is_byte = live && !i_end_of_input;

    // Character classes of the incoming byte.
    assign c_letter = ((i_input_byte >= "a") && (i_input_byte <= "z")) ||
                      ((i_input_byte >= "A") && (i_input_byte <= "Z"));
    assign c_digit  = (i_input_byte >= "0") && (i_input_byte <= "9");
    assign c_space  = (i_input_byte == " ") ||
                      ((i_input_byte >= 8'd9) && (i_input_byte <= 8'd13));
    assign c_under  = (i_input_byte == "_");
    assign c_op4    = (i_input_byte == ">") || (i_input_byte == "<") ||
                      (i_input_byte == "=") || (i_input_byte == "!");
    assign c_op1    = (i_input_byte == "+") || (i_input_byte == "-") ||
                      (i_input_byte == "*") || (i_input_byte == "/");
    assign c_sep    = (i_input_byte == "(") || (i_input_byte == ")") ||
                      (i_input_byte == "{") || (i_input_byte == "}") ||
                      (i_input_byte == ";") || (i_input_byte == ",");

    // The byte extends the current word or number, or completes an operator pair.
    assign cont    = ((r_mode == MODE_WORD) && (c_letter || c_digit || c_under)) ||
                     ((r_mode == MODE_DIGITS) && c_digit);
    assign op_pair = (r_mode == MODE_OPER) && (i_input_byte == "=");

    // Mode entered when the byte starts a new token.
    always_comb begin
        if (c_space || c_op1 || c_sep) begin
            start_mode = MODE_IDLE;
        end else if (c_letter) begin
            start_mode = MODE_WORD;
        end else if (c_digit) begin
            start_mode = MODE_DIGITS;
        end else if (c_op4) begin
            start_mode = MODE_OPER;
        end else begin
            start_mode = MODE_HALT;
        end
    end

    // Keyword match on the stored prefix of the pending word.
    assign kw_len   = (!r_ovf && (32'(r_count) <= 32'd8)) ? r_count[3:0] : 4'd0;
    assign kw_res   = kw_lookup(r_prefix, kw_len);
    assign word_len = (32'(r_count) > 32'd63) ? 6'd63 : 6'(r_count);

    // Record for the token that is pending in the scanner.
    always_comb begin
        flush_v   = 1'b1;
        flush_rec = '{cls: CLS_IDENT, kw: 3'd0, len: word_len, trunc: r_ovf,
                      c1: r_prefix[0], c2: 8'd0, pos: r_start, last: 1'b0};
        case (r_mode)
            MODE_WORD: begin
                if (kw_res[3]) begin
                    flush_rec.cls = CLS_KEYWORD;
                    flush_rec.kw  = kw_res[2:0];
                end
            end
            MODE_DIGITS: begin
                flush_rec.cls = CLS_NUMBER;
            end
            MODE_OPER: begin
                flush_rec.cls   = CLS_OPER;
                flush_rec.len   = 6'd1;
                flush_rec.trunc = 1'b0;
                flush_rec.c1    = r_pend;
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase
    end

    // Record for a byte that forms a token of its own.
    always_comb begin
        start_v   = c_op1 || c_sep || (start_mode == MODE_HALT);
        start_rec = '{cls: CLS_ERROR, kw: 3'd0, len: 6'd1, trunc: 1'b0,
                      c1: i_input_byte, c2: 8'd0, pos: r_pos, last: 1'b1};
        if (c_op1) begin
            start_rec.cls = CLS_OPER;
        end else if (c_sep) begin
            start_rec.cls = CLS_SEP;
        end
    end

    // Next scanner mode.
    always_comb begin
        n_mode = r_mode;
        if (live) begin
            if (i_end_of_input) begin
                n_mode = MODE_IDLE;
            end else if (cont) begin
                n_mode = r_mode;
            end else if (op_pair) begin
                n_mode = MODE_IDLE;
            end else begin
                n_mode = start_mode;
            end
        end
    end

    // Records, token text and position updates for the accepted beat.
    always_comb begin
        va    = 1'b0;
        vb    = 1'b0;
        rec_a = flush_rec;
        rec_b = start_rec;
        if (live && i_end_of_input) begin
            va    = flush_v;
            vb    = 1'b1;
            rec_b = '{cls: CLS_END, kw: 3'd0, len: 6'd0, trunc: 1'b0,
                      c1: 8'd0, c2: 8'd0, pos: r_pos, last: 1'b1};
        end else if (is_byte && op_pair) begin
            va    = 1'b1;
            rec_a = '{cls: CLS_OPER, kw: 3'd0, len: 6'd2, trunc: 1'b0,
                      c1: r_pend, c2: "=", pos: r_start, last: 1'b1};
        end else if (is_byte && !cont) begin
            va = flush_v;
            vb = start_v;
        end
        rec_a.last = !vb;

        // Compact so the first record always sits in rec0.
        o_push.n    = {1'b0, va} + {1'b0, vb};
        o_push.rec0 = va ? rec_a : rec_b;
        o_push.rec1 = rec_b;

        // Positions.
        n_pos   = r_pos;
        n_start = r_start;
        n_pend  = r_pend;
        if (live && i_end_of_input) begin
            n_pos = 32'd0;
        end else if (is_byte) begin
            n_pos = r_pos + 32'd1;
            if (!cont && !op_pair && (c_letter || c_digit || c_op4)) begin
                n_start = r_pos;
            end
            if (!cont && !op_pair && c_op4) begin
                n_pend = i_input_byte;
            end
        end

        // Text buffer: a new word restarts the count, then the byte is appended.
        do_append = is_byte && (cont || (!op_pair && (c_letter || c_digit)));
        app_count = (is_byte && !cont) ? '0 : r_count;
        n_prefix  = r_prefix;
        n_count   = r_count;
        n_ovf     = r_ovf;
        if (do_append) begin
            n_ovf = cont ? r_ovf : 1'b0;
            if (32'(app_count) < 32'(MAX_TEXT_SIZE - 1)) begin
                if (32'(app_count) < 32'(PREFIX_LEN)) begin
                    n_prefix[app_count[2:0]] = i_input_byte;
                end
                n_count = app_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 8'd0;
            r_start <= 32'd0;
            r_pos   <= 32'd0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    // Prefix bytes are written before they are read and need no reset.
    always_ff @(posedge i_clk) begin
        r_prefix <= n_prefix;
    end

    // Once an invalid byte has been seen the scanner stays halted.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALT) |=> (r_mode == MODE_HALT))
        else $error("scanner left the halted mode without reset");

    // Of two records from one beat, only the second closes the run.
    a_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == 2'd2) |-> (!o_push.rec0.last && o_push.rec1.last))
        else $error("wrong run marker on a record pair");

    // The stored character count never reaches the buffer size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < 32'(MAX_TEXT_SIZE))
        else $error("character count beyond buffer size");

endmodule

// ----- sv/stt_queue.sv -----
// ============================================================================
// stt_queue: token record queue
// Small register queue between scanner and output stage. Takes up to two
// records per cycle and releases one per pop.
// ============================================================================
module stt_queue import stt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_space_ok,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_rec  o_rec
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_rec          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_count, n_count;

    // Room for two records is required before a beat is taken.
    assign o_space_ok = (32'(r_count) <= 32'(QUEUE_DEPTH - 2));
    assign o_nonempty = (r_count != '0);
    assign o_rec      = r_mem[r_rd];

    // Pointer and fill level update.
    always_comb begin
        n_wr    = r_wr + PW'(i_push.n);
        n_rd    = r_rd + PW'(i_pop);
        n_count = r_count + (PW + 1)'(i_push.n) - (PW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.rec1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(QUEUE_DEPTH))
        else $error("record queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_space_ok)
        else $error("records pushed without room");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("record popped from empty queue");

endmodule

// ----- sv/stt_back.sv -----
// ============================================================================
// stt_back: result output stage
// Pulls records from the queue into the output register and hands them out
// over the result channel.
// ============================================================================
module stt_back import stt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_nonempty,
    input  t_rec i_rec,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_rec o_rec
);

    logic r_valid, n_valid;
    t_rec r_rec;

    // Load a new record whenever the register is empty or being taken.
    assign o_pop   = i_nonempty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ----- dv/source_text_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// source_text_tokenizer_unit_tb: self-checking testbench for the tokenizer
// Feeds byte streams through the input channel and predicts every token
// record that the scanner must produce. Each record taken from the result
// channel is checked field by field against the oldest prediction. Both
// channels idle at random, the result channel is held off for a long stretch
// once, and the run ends with an invalid byte that halts the scanner.
// ============================================================================
module source_text_tokenizer_unit_tb;
    import stt_pkg::*;

    localparam int TEXT_LIMIT  = MAX_TEXT_SIZE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    // Clock, reset and block ports.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_input_byte   = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_token_class;
    logic [2:0]  o_keyword_index;
    logic [5:0]  o_token_length;
    logic        o_truncated;
    logic [7:0]  o_first_char;
    logic [7:0]  o_second_char;
    logic [31:0] o_start_position;
    logic        o_last_of_run;

    // Token records still owed by the block, oldest first.
    t_rec        expected_tokens [$];
    t_rec        seen_token;
    t_rec        due_token;
    int          fail_count    = 0;
    int          cycle_count   = 0;

    // Idle rates in percent, and the long result hold-off request.
    int          send_idle_pct = 36;
    int          recv_idle_pct = 78;
    int          stall_req_len = 0;
    int          stall_req_id  = 0;
    int          stall_seen_id = 0;
    int          stall_left    = 0;

    // Scanner state as the testbench tracks it.
    t_mode       scan_state    = MODE_IDLE;
    logic [7:0]  word_prefix [8];
    int unsigned word_count    = 0;
    logic        word_overflow = 1'b0;
    logic [7:0]  pending_op    = 8'h00;
    logic [31:0] token_begin   = 32'd0;
    logic [31:0] stream_offset = 32'd0;

    string reserved_words [6] = '{"var", "if", "else", "while", "function", "return"};
    string letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string digit_set  = "0123456789";
    string symbol_set = "+-*/><=!(){};,";

    source_text_tokenizer_unit #(
        .MAX_TEXT_SIZE(TEXT_LIMIT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_input_byte    (i_input_byte),
        .i_end_of_input  (i_end_of_input),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_token_class   (o_token_class),
        .o_keyword_index (o_keyword_index),
        .o_token_length  (o_token_length),
        .o_truncated     (o_truncated),
        .o_first_char    (o_first_char),
        .o_second_char   (o_second_char),
        .o_start_position(o_start_position),
        .o_last_of_run   (o_last_of_run)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Character classes of the scanner.
    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Queues one predicted token record.
    function automatic void push_token(input t_cls cls, input logic [2:0] kw,
                                       input int unsigned len, input logic trunc,
                                       input logic [7:0] c1, input logic [7:0] c2,
                                       input logic [31:0] pos);
        t_rec r;
        r.cls   = cls;
        r.kw    = kw;
        r.len   = (len > 63) ? 6'd63 : len[5:0];
        r.trunc = trunc;
        r.c1    = c1;
        r.c2    = c2;
        r.pos   = pos;
        r.last  = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    // Adds one character to the word or number being built, saturating.
    function automatic void grow_word(input logic [7:0] b);
        if (word_count < TEXT_LIMIT - 1) begin
            if (word_count < 8) word_prefix[word_count] = b;
            word_count++;
        end else begin
            word_overflow = 1'b1;
        end
    endfunction

    // Emits whatever token is pending and returns to the idle state.
    function automatic void flush_pending();
        t_cls       cls;
        logic [2:0] kw;
        bit         same;
        string      w;
        cls = CLS_IDENT;
        kw  = 3'd0;
        case (scan_state)
            MODE_WORD: begin
                // Only an untruncated word of at most eight characters can be a keyword.
                if (!word_overflow && word_count <= 8) begin
                    for (int k = 0; k < 6; k++) begin
                        w = reserved_words[k];
                        if (cls == CLS_IDENT && word_count == w.len()) begin
                            same = 1'b1;
                            for (int i = 0; i < w.len(); i++) begin
                                if (word_prefix[i] != w[i]) same = 1'b0;
                            end
                            if (same) begin
                                cls = CLS_KEYWORD;
                                kw  = 3'(k);
                            end
                        end
                    end
                end
                push_token(cls, kw, word_count, word_overflow, word_prefix[0], 8'h00,
                           token_begin);
            end
            MODE_DIGITS: begin
                push_token(CLS_NUMBER, 3'd0, word_count, word_overflow, word_prefix[0],
                           8'h00, token_begin);
            end
            MODE_OPER: begin
                push_token(CLS_OPER, 3'd0, 1, 1'b0, pending_op, 8'h00, token_begin);
            end
            default: ;
        endcase
        scan_state = MODE_IDLE;
    endfunction

    // Handles a byte that arrives between tokens.
    function automatic void open_token(input logic [7:0] b, input logic [31:0] pos);
        if (is_blank(b)) begin
            return;
        end else if (is_alpha(b) || is_num(b)) begin
            scan_state    = is_alpha(b) ? MODE_WORD : MODE_DIGITS;
            word_count    = 0;
            word_overflow = 1'b0;
            token_begin   = pos;
            grow_word(b);
        end else if (b == ">" || b == "<" || b == "=" || b == "!") begin
            scan_state  = MODE_OPER;
            pending_op  = b;
            token_begin = pos;
        end else if (b == "+" || b == "-" || b == "*" || b == "/") begin
            push_token(CLS_OPER, 3'd0, 1, 1'b0, b, 8'h00, pos);
        end else if (b == "(" || b == ")" || b == "{" || b == "}" || b == ";" || b == ",") begin
            push_token(CLS_SEP, 3'd0, 1, 1'b0, b, 8'h00, pos);
        end else begin
            scan_state = MODE_HALT;
            push_token(CLS_ERROR, 3'd0, 1, 1'b0, b, 8'h00, pos);
        end
    endfunction

    // Predicts the token records caused by one accepted input beat.
    function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
        int          queued;
        logic [31:0] pos;
        t_rec        r;
        queued = expected_tokens.size();
        if (scan_state == MODE_HALT) return;
        if (eoi) begin
            flush_pending();
            push_token(CLS_END, 3'd0, 0, 1'b0, 8'h00, 8'h00, stream_offset);
            scan_state    = MODE_IDLE;
            stream_offset = 32'd0;
        end else begin
            pos           = stream_offset;
            stream_offset = stream_offset + 32'd1;
            case (scan_state)
                MODE_WORD: begin
                    if (is_alpha(b) || is_num(b) || b == "_") begin
                        grow_word(b);
                    end else begin
                        flush_pending();
                        open_token(b, pos);
                    end
                end
                MODE_DIGITS: begin
                    if (is_num(b)) begin
                        grow_word(b);
                    end else begin
                        flush_pending();
                        open_token(b, pos);
                    end
                end
                MODE_OPER: begin
                    if (b == "=") begin
                        push_token(CLS_OPER, 3'd0, 2, 1'b0, pending_op, "=", token_begin);
                        scan_state = MODE_IDLE;
                    end else begin
                        flush_pending();
                        open_token(b, pos);
                    end
                end
                default: open_token(b, pos);
            endcase
        end
        // The final record of the beat carries the last-of-run mark.
        if (expected_tokens.size() > queued) begin
            r      = expected_tokens.pop_back();
            r.last = 1'b1;
            expected_tokens.push_back(r);
        end
    endfunction

    // Sends one input beat, idling first at the current rate.
    task automatic send_beat(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_input_byte   <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    // Sends one random piece of well-formed source text, or a noise byte.
    task automatic send_random_chunk(output int beats);
        int    pick;
        int    len;
        string w;
        pick  = $urandom_range(99);
        beats = 0;
        if (pick < 30) begin
            // Keyword, or an identifier that is now and then longer than the buffer.
            if ($urandom_range(2) == 0) begin
                w = reserved_words[$urandom_range(5)];
                send_text(w);
                beats = w.len();
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
                send_beat(pick_from(letter_set), 1'b0);
                for (int i = 1; i < len; i++) begin
                    case ($urandom_range(3))
                        0: send_beat(pick_from(digit_set), 1'b0);
                        1: send_beat("_", 1'b0);
                        default: send_beat(pick_from(letter_set), 1'b0);
                    endcase
                end
                beats = len;
            end
        end else if (pick < 45) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_beat(pick_from(digit_set), 1'b0);
            beats = len;
        end else if (pick < 60) begin
            if ($urandom_range(1)) begin
                send_beat(pick_from("+-*/"), 1'b0);
                beats = 1;
            end else begin
                send_beat(pick_from("><=!"), 1'b0);
                beats = 1;
                if ($urandom_range(1)) begin
                    send_beat("=", 1'b0);
                    beats = 2;
                end
            end
        end else if (pick < 70) begin
            send_beat(pick_from("(){};,"), 1'b0);
            beats = 1;
        end else if (pick < 85) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) send_beat(pick_blank(), 1'b0);
            beats = len;
        end else if (pick < 93) begin
            send_beat(pick_from(symbol_set), 1'b0);
            beats = 1;
        end else begin
            // End of stream; the byte lane is ignored, so any value goes.
            send_beat(8'($urandom_range(255)), 1'b1);
            beats = 1;
        end
        if (pick < 60 && $urandom_range(99) < 40) begin
            send_beat(pick_blank(), 1'b0);
            beats++;
        end
    endtask

    // Words, an underscore, a two-character operator, a lone bang, end flushing a word.
    task automatic test_words_and_bang();
        send_text("if a_9>=!x");
        send_beat(8'hFF, 1'b1);
    endtask

    // Equality, a lone operator cut by a tab, a number closed by a separator.
    task automatic test_compound_operators();
        send_text("==<\t12}+");
        send_beat(8'h00, 1'b1);
    endtask

    // The operators -, * and /, every separator, then a number cut by end.
    task automatic test_symbols();
        send_text("-*/(){};,5");
        send_beat(8'h80, 1'b1);
    endtask

    // Random source text under one pair of idle rates.
    task automatic test_random_stream(input int send_pct, input int recv_pct, input int count);
        int sent;
        int beats;
        send_idle_pct  = send_pct;
        recv_idle_pct <= recv_pct;
        sent = 0;
        while (sent < count) begin
            send_random_chunk(beats);
            sent += beats;
        end
    endtask

    // Long result hold-off while the sender keeps offering beats.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        stall_req_len <= 90;
        stall_req_id  <= stall_req_id + 1;
        send_text("while(x1>=42){y=y+1;}");
        send_text("return(a,b);");
    endtask

    // An invalid byte halts the scanner; nothing after it yields a record.
    task automatic test_invalid_halt();
        logic [7:0] bad;
        case ($urandom_range(3))
            0:       bad = 8'h00;
            1:       bad = 8'($urandom_range(128, 255));
            2:       bad = "_";
            default: bad = pick_from("#@~?.$");
        endcase
        // An underscore would only extend a pending word, so it follows an operator.
        if (bad != "_" && $urandom_range(1)) begin
            send_text("ab");
        end else begin
            send_text(">");
        end
        send_beat(bad, 1'b0);
        send_text("x=");
        send_beat(8'h20, 1'b1);
        send_text("1;");
    endtask

    // Result channel ready: random idling, or a counted hold-off when requested.
    always @(posedge i_clk) begin
        if (stall_req_id != stall_seen_id) begin
            stall_seen_id <= stall_req_id;
            stall_left    <= stall_req_len;
            i_out_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_token = '{cls: t_cls'(o_token_class), kw: o_keyword_index,
                           len: o_token_length, trunc: o_truncated, c1: o_first_char,
                           c2: o_second_char, pos: o_start_position, last: o_last_of_run};
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected record, class %0d first char %0d", $time,
                         o_token_class, o_first_char);
                fail_count++;
            end else begin
                due_token = expected_tokens.pop_front();
                check_field("token_class", 32'(due_token.cls), 32'(seen_token.cls));
                check_field("keyword_index", 32'(due_token.kw), 32'(seen_token.kw));
                check_field("token_length", 32'(due_token.len), 32'(seen_token.len));
                check_field("truncated", 32'(due_token.trunc), 32'(seen_token.trunc));
                check_field("first_char", 32'(due_token.c1), 32'(seen_token.c1));
                check_field("second_char", 32'(due_token.c2), 32'(seen_token.c2));
                check_field("start_position", due_token.pos, seen_token.pos);
                check_field("last_of_run", 32'(due_token.last), 32'(seen_token.last));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("source_text_tokenizer_unit_tb: errors");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_words_and_bang();
        test_compound_operators();
        test_symbols();
        test_random_stream(36, 78, 180);
        test_random_stream(78, 36, 180);
        test_random_stream(0, 0, 180);
        test_output_backpressure();
        test_invalid_halt();
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("source_text_tokenizer_unit_tb: clean");
        end else begin
            $display("source_text_tokenizer_unit_tb: errors");
        end
        $finish;
    end

endmodule
